>>> rtl/rnpm_pkg.sv
// shared constants and codes for the radius nearest point matcher
`timescale 1ns / 1ps

package rnpm_pkg;

   // request operation codes
   localparam logic [1:0] OP_CLEAR      = 2'd0;
   localparam logic [1:0] OP_LOAD_DET   = 2'd1;
   localparam logic [1:0] OP_LOAD_FEAT  = 2'd2;
   localparam logic [1:0] OP_QUERY      = 2'd3;

   // response source codes
   localparam logic [1:0] SRC_NONE      = 2'd0;
   localparam logic [1:0] SRC_DET       = 2'd1;
   localparam logic [1:0] SRC_FEAT      = 2'd2;

   // default sizes
   localparam int DETECTOR_DEPTH_DEFAULT = 64;
   localparam int FEATURE_DEPTH_DEFAULT  = 64;
   localparam int COORD_BITS_DEFAULT     = 11;

   // radius register and distance widths
   localparam int RADIUS_BITS  = 8;
   localparam int RADIUS_SQ_BITS = 2 * RADIUS_BITS + 1;
   localparam int SQRT_IN_BITS = 2 * RADIUS_BITS;
   localparam int SQRT_STEPS   = RADIUS_BITS;
   localparam int REM_BITS     = RADIUS_BITS + 2;
   localparam int BEST_BITS    = 14;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 8'd10;
   localparam logic [RADIUS_SQ_BITS-1:0] RADIUS_SQ_RESET =
      RADIUS_SQ_BITS'((int'(RADIUS_RESET) + 1) * (int'(RADIUS_RESET) + 1));

   // best distance before any candidate is taken
   localparam logic [BEST_BITS-1:0] NO_MATCH_DIST = 14'd9999;

endpackage

>>> rtl/radius_nearest_point_matcher.sv
// radius nearest point matcher: point tables, scan pipeline and response register
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid/req_ready): op, pos_x, pos_y. A clear or a load
//   gives no response; a load into a full table is dropped. A query starts a
//   scan of the detector table, then the feature table.
//   rsp channel (rsp_valid/rsp_ready): one transaction per query with the chosen
//   point, its source and its floored distance, or the query point as estimate.
//   csr channel (csr_valid/csr_ready): writes match_radius, always ready; write it
//   only while no query is in flight.
//   The tables sit in simple dual-port memories read one entry a cycle; after
//   the read each entry goes through an 11-stage distance pipeline (abs
//   difference, squares, radius check, 8 one-bit square root steps) before the
//   best-so-far update.
//   req_ready is high only between queries, so no load can touch a table that
//   a scan is reading; the next request can be taken in the cycle rsp_valid rises.
//   A finished result waits in the response register; the next request is
//   taken meanwhile, and a second query holds its result until the register
//   frees up.
//   Reset: synchronous, active high; both tables empty, radius 10, no response.

module radius_nearest_point_matcher #(
   parameter int DETECTOR_DEPTH = rnpm_pkg::DETECTOR_DEPTH_DEFAULT,
   parameter int FEATURE_DEPTH  = rnpm_pkg::FEATURE_DEPTH_DEFAULT,
   parameter int COORD_BITS     = rnpm_pkg::COORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic [COORD_BITS-1:0]            req_pos_x,
   input  logic [COORD_BITS-1:0]            req_pos_y,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [COORD_BITS-1:0]            rsp_match_x,
   output logic [COORD_BITS-1:0]            rsp_match_y,
   output logic [1:0]                       rsp_source,
   output logic [rnpm_pkg::RADIUS_BITS-1:0] rsp_match_distance,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rnpm_pkg::RADIUS_BITS-1:0] csr_match_radius
);

   localparam int DAW = (DETECTOR_DEPTH > 1) ? $clog2(DETECTOR_DEPTH) : 1;
   localparam int FAW = (FEATURE_DEPTH > 1) ? $clog2(FEATURE_DEPTH) : 1;
   localparam int DCW = $clog2(DETECTOR_DEPTH + 1);
   localparam int FCW = $clog2(FEATURE_DEPTH + 1);
   localparam int IW  = (DCW > FCW) ? DCW : FCW;
   localparam int PW  = 2 * COORD_BITS;
   localparam int SQW = 2 * COORD_BITS;
   localparam int SW  = 2 * COORD_BITS + 1;
   localparam int RB  = rnpm_pkg::RADIUS_BITS;
   localparam int SIB = rnpm_pkg::SQRT_IN_BITS;
   localparam int NST = rnpm_pkg::SQRT_STEPS;
   localparam int RMB = rnpm_pkg::REM_BITS;
   localparam int BB  = rnpm_pkg::BEST_BITS;
   localparam int RSB = rnpm_pkg::RADIUS_SQ_BITS;

   // state codes
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // control registers
   logic [1:0]     state_ff, state_in;
   logic [DCW-1:0] det_count_ff, det_count_in;
   logic [FCW-1:0] feat_count_ff, feat_count_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           phase_ff, phase_in;
   logic           found_ff, found_in;
   logic [RSB-1:0] radius_sq_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   // query and best candidate
   logic [COORD_BITS-1:0] qx_ff, qy_ff;
   logic [BB-1:0]         best_ff;
   logic [COORD_BITS-1:0] best_x_ff, best_y_ff;
   logic [1:0]            best_src_ff;

   // response register
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [1:0]            rsp_src_ff;
   logic [RB-1:0]         rsp_dist_ff;

   // point memories
   logic [PW-1:0] det_mem [DETECTOR_DEPTH];
   logic [PW-1:0] feat_mem [FEATURE_DEPTH];
   logic [PW-1:0] rd_det_ff, rd_feat_ff;

   // scan pipeline
   logic                  rd_valid_ff, ab_valid_ff, sq_valid_ff;
   logic [1:0]            rd_src_ff, ab_src_ff, sq_src_ff;
   logic [COORD_BITS-1:0] ab_x_ff, ab_y_ff, ab_dx_ff, ab_dy_ff;
   logic [COORD_BITS-1:0] sq_x_ff, sq_y_ff;
   logic [SQW-1:0]        sq_xx_ff, sq_yy_ff;
   logic [NST:0]          rt_valid_ff, rt_valid_in;
   logic [1:0]            rt_src_ff [NST+1];
   logic [COORD_BITS-1:0] rt_x_ff [NST+1];
   logic [COORD_BITS-1:0] rt_y_ff [NST+1];
   logic [SIB-1:0]        rt_s_ff [NST+1];
   logic [RMB-1:0]        rt_rem_ff [NST+1];
   logic [RMB-1:0]        rt_rem_in [NST+1];
   logic [RB-1:0]         rt_root_ff [NST+1];
   logic [RB-1:0]         rt_root_in [NST+1];

   logic                  req_fire, query_fire, rsp_free, pipe_busy, finish_now;
   logic                  det_we, feat_we, iss_valid;
   logic [1:0]            iss_src;
   logic [PW-1:0]         rd_pt;
   logic [COORD_BITS-1:0] rd_x, rd_y;
   logic [SW-1:0]         sum;
   logic                  in_range;
   logic                  take_cand;
   logic [RB:0]           csr_rad_p1;
   logic [2*RB+1:0]       csr_rad_sq;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign query_fire = req_fire && (req_op == rnpm_pkg::OP_QUERY);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign pipe_busy  = rd_valid_ff || ab_valid_ff || sq_valid_ff || (|rt_valid_ff);
   assign finish_now = (state_ff == ST_FINISH) && !pipe_busy && rsp_free;
   assign det_we     = req_fire && (req_op == rnpm_pkg::OP_LOAD_DET) &&
                       (det_count_ff < DCW'(DETECTOR_DEPTH));
   assign feat_we    = req_fire && (req_op == rnpm_pkg::OP_LOAD_FEAT) &&
                       (feat_count_ff < FCW'(FEATURE_DEPTH));

   // control next state
   always_comb begin
      state_in      = state_ff;
      det_count_in  = det_count_ff;
      feat_count_in = feat_count_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      iss_valid     = 1'b0;
      iss_src       = rnpm_pkg::SRC_DET;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  rnpm_pkg::OP_CLEAR: begin
                     det_count_in  = '0;
                     feat_count_in = '0;
                  end
                  rnpm_pkg::OP_LOAD_DET: begin
                     if (det_we) det_count_in = det_count_ff + 1'b1;
                  end
                  rnpm_pkg::OP_LOAD_FEAT: begin
                     if (feat_we) feat_count_in = feat_count_ff + 1'b1;
                  end
                  default: begin
                     idx_in   = '0;
                     phase_in = 1'b0;
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!phase_ff) begin
               if (idx_ff < IW'(det_count_ff)) begin
                  iss_valid = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end else begin
                  phase_in = 1'b1;
                  idx_in   = '0;
               end
            end else begin
               iss_src = rnpm_pkg::SRC_FEAT;
               if (idx_ff < IW'(feat_count_ff)) begin
                  iss_valid = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (finish_now) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (finish_now) rsp_valid_in = 1'b1;
   end

   // radius plus one, squared, so a floored distance within radius is sum below it
   assign csr_rad_p1 = {1'b0, csr_match_radius} + 1'b1;
   assign csr_rad_sq = csr_rad_p1 * csr_rad_p1;
   assign csr_ready  = 1'b1;

   // best candidate from the last square root stage
   assign take_cand = rt_valid_ff[NST] && ((BB'(rt_root_ff[NST])) < best_ff);
   always_comb begin
      found_in = found_ff;
      if (query_fire) found_in = 1'b0;
      else if (take_cand) found_in = 1'b1;
   end

   // control registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         det_count_ff  <= '0;
         feat_count_ff <= '0;
         idx_ff        <= '0;
         phase_ff      <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         radius_sq_ff  <= rnpm_pkg::RADIUS_SQ_RESET;
         rd_valid_ff   <= 1'b0;
         ab_valid_ff   <= 1'b0;
         sq_valid_ff   <= 1'b0;
         rt_valid_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         det_count_ff  <= det_count_in;
         feat_count_ff <= feat_count_in;
         idx_ff        <= idx_in;
         phase_ff      <= phase_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) radius_sq_ff <= csr_rad_sq[RSB-1:0];
         rd_valid_ff   <= iss_valid;
         ab_valid_ff   <= rd_valid_ff;
         sq_valid_ff   <= ab_valid_ff;
         rt_valid_ff   <= rt_valid_in;
      end
   end

   // detector table memory
   always_ff @(posedge clock) begin
      if (det_we) det_mem[det_count_ff[DAW-1:0]] <= {req_pos_x, req_pos_y};
      rd_det_ff <= det_mem[idx_ff[DAW-1:0]];
   end

   // feature table memory
   always_ff @(posedge clock) begin
      if (feat_we) feat_mem[feat_count_ff[FAW-1:0]] <= {req_pos_x, req_pos_y};
      rd_feat_ff <= feat_mem[idx_ff[FAW-1:0]];
   end

   // pick the table word and form the squared distance
   assign rd_pt    = (rd_src_ff == rnpm_pkg::SRC_FEAT) ? rd_feat_ff : rd_det_ff;
   assign rd_x     = rd_pt[PW-1:COORD_BITS];
   assign rd_y     = rd_pt[COORD_BITS-1:0];
   assign sum      = SW'(sq_xx_ff) + SW'(sq_yy_ff);
   assign in_range = (sum[SW-1:SIB] == '0) && ({1'b0, sum[SIB-1:0]} < radius_sq_ff);

   // one result bit per square root stage
   always_comb begin
      logic [RMB+1:0] tmp;
      logic [RMB+1:0] trial;
      rt_valid_in[0] = sq_valid_ff && in_range;
      rt_rem_in[0]   = '0;
      rt_root_in[0]  = '0;
      tmp            = '0;
      trial          = '0;
      for (int k = 0; k < NST; k++) begin
         tmp   = {rt_rem_ff[k], rt_s_ff[k][SIB-1-2*k -: 2]};
         trial = (RMB+2)'({rt_root_ff[k], 2'b01});
         rt_valid_in[k+1] = rt_valid_ff[k];
         if (tmp >= trial) begin
            rt_rem_in[k+1]  = RMB'(tmp - trial);
            rt_root_in[k+1] = {rt_root_ff[k][RB-2:0], 1'b1};
         end else begin
            rt_rem_in[k+1]  = tmp[RMB-1:0];
            rt_root_in[k+1] = {rt_root_ff[k][RB-2:0], 1'b0};
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      rd_src_ff <= iss_src;
      ab_src_ff <= rd_src_ff;
      ab_x_ff   <= rd_x;
      ab_y_ff   <= rd_y;
      ab_dx_ff  <= (rd_x > qx_ff) ? rd_x - qx_ff : qx_ff - rd_x;
      ab_dy_ff  <= (rd_y > qy_ff) ? rd_y - qy_ff : qy_ff - rd_y;
      sq_src_ff <= ab_src_ff;
      sq_x_ff   <= ab_x_ff;
      sq_y_ff   <= ab_y_ff;
      sq_xx_ff  <= SQW'(ab_dx_ff) * SQW'(ab_dx_ff);
      sq_yy_ff  <= SQW'(ab_dy_ff) * SQW'(ab_dy_ff);
      rt_src_ff[0]  <= sq_src_ff;
      rt_x_ff[0]    <= sq_x_ff;
      rt_y_ff[0]    <= sq_y_ff;
      rt_s_ff[0]    <= sum[SIB-1:0];
      rt_rem_ff[0]  <= rt_rem_in[0];
      rt_root_ff[0] <= rt_root_in[0];
      for (int k = 1; k <= NST; k++) begin
         rt_src_ff[k]  <= rt_src_ff[k-1];
         rt_x_ff[k]    <= rt_x_ff[k-1];
         rt_y_ff[k]    <= rt_y_ff[k-1];
         rt_s_ff[k]    <= rt_s_ff[k-1];
         rt_rem_ff[k]  <= rt_rem_in[k];
         rt_root_ff[k] <= rt_root_in[k];
      end
   end

   // query point, best candidate and response payload
   always_ff @(posedge clock) begin
      if (query_fire) begin
         qx_ff   <= req_pos_x;
         qy_ff   <= req_pos_y;
         best_ff <= rnpm_pkg::NO_MATCH_DIST;
      end else if (take_cand) begin
         best_ff     <= BB'(rt_root_ff[NST]);
         best_x_ff   <= rt_x_ff[NST];
         best_y_ff   <= rt_y_ff[NST];
         best_src_ff <= rt_src_ff[NST];
      end
      if (finish_now) begin
         if (found_ff) begin
            rsp_x_ff    <= best_x_ff;
            rsp_y_ff    <= best_y_ff;
            rsp_src_ff  <= best_src_ff;
            rsp_dist_ff <= best_ff[RB-1:0];
         end else begin
            rsp_x_ff    <= qx_ff;
            rsp_y_ff    <= qy_ff;
            rsp_src_ff  <= rnpm_pkg::SRC_NONE;
            rsp_dist_ff <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_x        = rsp_x_ff;
   assign rsp_match_y        = rsp_y_ff;
   assign rsp_source         = rsp_src_ff;
   assign rsp_match_distance = rsp_dist_ff;

   // checks
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_busy)
      else $error("scan pipeline busy while idle");

   a_det_count_bound: assert property (@(posedge clock) disable iff (reset)
      det_count_ff <= DCW'(DETECTOR_DEPTH))
      else $error("detector count beyond depth");

   a_feat_count_bound: assert property (@(posedge clock) disable iff (reset)
      feat_count_ff <= FCW'(FEATURE_DEPTH))
      else $error("feature count beyond depth");

   a_found_dist: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_ff <= BB'((1 << RB) - 1)))
      else $error("best distance out of radius range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_src_ff == rnpm_pkg::SRC_NONE && rsp_dist_ff == '0) ||
                        rsp_src_ff == rnpm_pkg::SRC_DET ||
                        rsp_src_ff == rnpm_pkg::SRC_FEAT))
      else $error("bad response source or distance");

endmodule

>>> tb/radius_nearest_point_matcher_test.sv
// self-checking testbench for the radius nearest point matcher
`timescale 1ns / 1ps

module radius_nearest_point_matcher_test;

   localparam int CW         = rnpm_pkg::COORD_BITS_DEFAULT;
   localparam int RB         = rnpm_pkg::RADIUS_BITS;
   localparam int DET_DEPTH  = rnpm_pkg::DETECTOR_DEPTH_DEFAULT;
   localparam int FEAT_DEPTH = rnpm_pkg::FEATURE_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_HOLD_CYCLES = 1500;
   localparam int PHASE_ITEMS = 170;

   typedef logic [CW-1:0] coord_type;

   typedef struct packed {
      logic [1:0] op;
      coord_type  x;
      coord_type  y;
      logic       wait_drain;
   } req_item_type;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      logic [1:0]  source;
      logic [RB-1:0] distance;
   } match_type;

   // block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_op = rnpm_pkg::OP_CLEAR;
   coord_type              req_pos_x = '0;
   coord_type              req_pos_y = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   coord_type              rsp_match_x;
   coord_type              rsp_match_y;
   logic [1:0]             rsp_source;
   logic [RB-1:0]          rsp_match_distance;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [RB-1:0]          csr_match_radius = '0;

   // predicted state of the block
   coord_type              det_x [DET_DEPTH];
   coord_type              det_y [DET_DEPTH];
   coord_type              feat_x [FEAT_DEPTH];
   coord_type              feat_y [FEAT_DEPTH];
   int unsigned            det_count = 0;
   int unsigned            feat_count = 0;
   int unsigned            radius_cfg = rnpm_pkg::RADIUS_RESET;

   // stimulus and scoreboard bookkeeping
   req_item_type pending_requests[$];
   match_type    expected_matches[$];
   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count = 0;
   bit          req_fire = 1'b0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int unsigned send_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned long_hold_asked = 0;
   int unsigned long_hold_done = 0;

   radius_nearest_point_matcher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_match_x        (rsp_match_x),
      .rsp_match_y        (rsp_match_y),
      .rsp_source         (rsp_source),
      .rsp_match_distance (rsp_match_distance),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_match_radius   (csr_match_radius)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor of the square root, one result bit at a time
   function automatic int unsigned floor_root(input int unsigned v);
      int unsigned r;
      int unsigned t;
      r = 0;
      for (int i = 12; i >= 0; i--) begin
         t = r | (32'd1 << i);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic int unsigned point_distance(input coord_type ax, input coord_type ay,
                                                  input coord_type bx, input coord_type by);
      int unsigned dx;
      int unsigned dy;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      return floor_root(dx * dx + dy * dy);
   endfunction

   // update the table image and queue the result of a query
   task automatic predict_request(input req_item_type it);
      match_type   res;
      int unsigned best;
      int unsigned d;
      case (it.op)
         rnpm_pkg::OP_CLEAR: begin
            det_count = 0;
            feat_count = 0;
         end
         rnpm_pkg::OP_LOAD_DET: begin
            if (det_count < DET_DEPTH) begin
               det_x[det_count] = it.x;
               det_y[det_count] = it.y;
               det_count++;
            end
         end
         rnpm_pkg::OP_LOAD_FEAT: begin
            if (feat_count < FEAT_DEPTH) begin
               feat_x[feat_count] = it.x;
               feat_y[feat_count] = it.y;
               feat_count++;
            end
         end
         default: begin
            best = rnpm_pkg::NO_MATCH_DIST;
            res.x = it.x;
            res.y = it.y;
            res.source = rnpm_pkg::SRC_NONE;
            res.distance = '0;
            // detector table first, strictly closer wins
            for (int i = 0; i < det_count; i++) begin
               d = point_distance(it.x, it.y, det_x[i], det_y[i]);
               if (d < best && d <= radius_cfg) begin
                  best = d;
                  res.x = det_x[i];
                  res.y = det_y[i];
                  res.source = rnpm_pkg::SRC_DET;
                  res.distance = RB'(d);
               end
            end
            for (int i = 0; i < feat_count; i++) begin
               d = point_distance(it.x, it.y, feat_x[i], feat_y[i]);
               if (d < best && d <= radius_cfg) begin
                  best = d;
                  res.x = feat_x[i];
                  res.y = feat_y[i];
                  res.source = rnpm_pkg::SRC_FEAT;
                  res.distance = RB'(d);
               end
            end
            expected_matches.insert(expected_matches.size(), res);
         end
      endcase
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned idle_gap(input bit calm);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (calm || pick < 55) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // monitor: check responses and track accepted requests
   always @(posedge clock) begin : monitor
      match_type    want;
      req_item_type it;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               $error("rsp: unexpected transaction, match_x %0d match_y %0d",
                      rsp_match_x, rsp_match_y);
               error_count++;
            end else begin
               want = expected_matches.pop_front();
               check_field("match_x", want.x, rsp_match_x);
               check_field("match_y", want.y, rsp_match_y);
               check_field("source", want.source, rsp_source);
               check_field("match_distance", want.distance, rsp_match_distance);
            end
         end
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            it.op = req_op;
            it.x = req_pos_x;
            it.y = req_pos_y;
            it.wait_drain = 1'b0;
            predict_request(it);
            accepted_count++;
         end
      end
   end

   // request driver, fed from the pending queue
   always @(negedge clock) begin : drive_requests
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].wait_drain && expected_matches.size() != 0)) begin
            it = pending_requests.pop_front();
            req_op <= it.op;
            req_pos_x <= it.x;
            req_pos_y <= it.y;
            req_valid <= 1'b1;
            send_gap = idle_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready with random stalls and an occasional long hold-off
   always @(negedge clock) begin : drive_ready
      if (long_hold_done != long_hold_asked) begin
         long_hold_done++;
         rsp_stall = LONG_HOLD_CYCLES;
      end
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!rsp_calm && $urandom_range(0, 7) == 0) begin
         rsp_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80)
                                                 : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_request(input logic [1:0] op, input coord_type x, input coord_type y,
                               input bit drain = 1'b0);
      req_item_type it;
      it.op = op;
      it.x = x;
      it.y = y;
      it.wait_drain = drain;
      pending_requests.insert(pending_requests.size(), it);
      queued_count++;
   endtask

   function automatic coord_type near_coord(input int c, input int spread);
      return coord_type'(c + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // loads around a center, with duplicates and mirrored points for ties, then queries
   task automatic push_cluster(input int spread);
      coord_type   xs[$];
      coord_type   ys[$];
      coord_type   x;
      coord_type   y;
      int          cx;
      int          cy;
      int unsigned n_load;
      int unsigned n_query;
      int unsigned k;
      int unsigned j;
      cx = $urandom_range(0, 2047);
      cy = $urandom_range(0, 2047);
      n_load = $urandom_range(0, 12);
      n_query = $urandom_range(1, 6);
      if ($urandom_range(0, 1) == 0)
         push_request(rnpm_pkg::OP_CLEAR, coord_type'($urandom), coord_type'($urandom));
      for (int i = 0; i < n_load; i++) begin
         k = $urandom_range(0, 9);
         if (k < 2 && xs.size() != 0) begin
            j = $urandom_range(0, xs.size() - 1);
            x = xs[j];
            y = ys[j];
         end else if (k < 4 && xs.size() != 0) begin
            x = coord_type'(2 * cx - int'(xs[$]));
            y = coord_type'(2 * cy - int'(ys[$]));
         end else begin
            x = near_coord(cx, spread);
            y = near_coord(cy, spread);
         end
         xs.insert(xs.size(), x);
         ys.insert(ys.size(), y);
         push_request($urandom_range(0, 1) ? rnpm_pkg::OP_LOAD_DET : rnpm_pkg::OP_LOAD_FEAT,
                      x, y);
      end
      for (int i = 0; i < n_query; i++) begin
         if ($urandom_range(0, 9) < 3 && xs.size() != 0) begin
            j = $urandom_range(0, xs.size() - 1);
            x = xs[j];
            y = ys[j];
         end else if ($urandom_range(0, 3) == 0) begin
            x = coord_type'(cx);
            y = coord_type'(cy);
         end else begin
            x = near_coord(cx, spread);
            y = near_coord(cy, spread);
         end
         push_request(rnpm_pkg::OP_QUERY, x, y, i == 0 && $urandom_range(0, 49) == 0);
      end
   endtask

   // both tables past full, so the extra loads get dropped
   task automatic push_table_fill(input int spread);
      int cx;
      int cy;
      cx = $urandom_range(0, 2047);
      cy = $urandom_range(0, 2047);
      push_request(rnpm_pkg::OP_CLEAR, '0, '0);
      repeat (DET_DEPTH + $urandom_range(1, 4))
         push_request(rnpm_pkg::OP_LOAD_DET, near_coord(cx, spread), near_coord(cy, spread));
      repeat (FEAT_DEPTH + $urandom_range(1, 4))
         push_request(rnpm_pkg::OP_LOAD_FEAT, near_coord(cx, spread), near_coord(cy, spread));
      repeat (4)
         push_request(rnpm_pkg::OP_QUERY, near_coord(cx, spread), near_coord(cy, spread));
   endtask

   task automatic push_random_sequence(input int spread);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         push_request(2'($urandom_range(0, 3)), coord_type'($urandom), coord_type'($urandom));
      else if (pick < 14)
         push_table_fill(spread);
      else
         push_cluster(spread);
   endtask

   // all requests taken, all responses back, then let a trailing load settle
   task automatic wait_until_idle();
      while (accepted_count != queued_count || expected_matches.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_radius(input logic [RB-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_match_radius <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      radius_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stimulus: directed cases at the reset radius, then random phases
   initial begin : stimulus
      logic [RB-1:0] radius;
      int unsigned   phase_end;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty tables give the query point back
      push_request(rnpm_pkg::OP_QUERY, 11'd0, 11'd0);
      push_request(rnpm_pkg::OP_QUERY, 11'd2047, 11'd2047);
      // equal points in both tables, detector wins
      push_request(rnpm_pkg::OP_LOAD_DET, 11'd100, 11'd100);
      push_request(rnpm_pkg::OP_LOAD_FEAT, 11'd100, 11'd100);
      push_request(rnpm_pkg::OP_QUERY, 11'd100, 11'd100, 1'b1);
      // radius edge: exactly 10, floored 10, floored 11
      push_request(rnpm_pkg::OP_QUERY, 11'd106, 11'd108);
      push_request(rnpm_pkg::OP_QUERY, 11'd107, 11'd108);
      push_request(rnpm_pkg::OP_QUERY, 11'd108, 11'd108);
      // a strictly closer feature point replaces the detector point
      push_request(rnpm_pkg::OP_LOAD_FEAT, 11'd103, 11'd100);
      push_request(rnpm_pkg::OP_QUERY, 11'd102, 11'd100);
      // two detector points at equal distance, the earlier one wins
      push_request(rnpm_pkg::OP_LOAD_DET, 11'd98, 11'd100);
      push_request(rnpm_pkg::OP_QUERY, 11'd99, 11'd100);
      // coordinate extremes
      push_request(rnpm_pkg::OP_LOAD_DET, 11'd0, 11'd0);
      push_request(rnpm_pkg::OP_LOAD_DET, 11'd2047, 11'd2047);
      push_request(rnpm_pkg::OP_QUERY, 11'd0, 11'd5);
      push_request(rnpm_pkg::OP_QUERY, 11'd2047, 11'd2040);
      push_request(rnpm_pkg::OP_QUERY, 11'd1024, 11'd0);
      // clear empties both tables
      push_request(rnpm_pkg::OP_CLEAR, 11'd2047, 11'd2047);
      push_request(rnpm_pkg::OP_QUERY, 11'd100, 11'd100);
      push_request(rnpm_pkg::OP_LOAD_FEAT, 11'd2047, 11'd0);
      push_request(rnpm_pkg::OP_QUERY, 11'd2040, 11'd0);
      wait_until_idle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: radius = 8'd0;
            1: radius = 8'd255;
            2: radius = 8'd1;
            4: radius = 8'd10;
            5: radius = 8'd200;
            7: radius = 8'd3;
            default: radius = RB'($urandom_range(2, 254));
         endcase
         write_radius(radius);
         req_calm = (p == 3);
         rsp_calm = (p == 6);
         if (p == 1) push_table_fill(int'(radius) + 3);
         // receiver holds off while the sender keeps offering queries
         if (p == 3) begin
            long_hold_asked++;
            push_cluster(int'(radius) + 3);
            repeat (30)
               push_request(rnpm_pkg::OP_QUERY, coord_type'($urandom), coord_type'($urandom));
         end
         phase_end = queued_count + PHASE_ITEMS;
         while (queued_count < phase_end) push_random_sequence(int'(radius) + 3);
         wait_until_idle();
      end

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #16_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
